// File: hw/rtl/hbs_pkg.sv
// Package with the constants and types of the heightmap bilinear sampler.
`default_nettype none

package hbs_pkg;

    localparam int COORD_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int CELL_BITS   = COORD_BITS - FRAC_BITS;
    localparam int HEIGHT_BITS = 16;
    localparam int ADDR_BITS   = 2 * CELL_BITS;
    localparam int DIM_BITS    = CELL_BITS + 1;
    localparam int WT_BITS     = 2 * FRAC_BITS + 1;
    localparam int PROD_BITS   = HEIGHT_BITS + WT_BITS + 1;
    localparam int ELEV_BITS   = 19;
    localparam int MAG_BITS    = ELEV_BITS + 1;
    localparam int SH_BITS     = PROD_BITS + 2;

    localparam logic [DIM_BITS-1:0] MAX_DIM  = DIM_BITS'(1 << CELL_BITS);
    localparam logic [FRAC_BITS:0]  FRAC_ONE = (FRAC_BITS + 1)'(1 << FRAC_BITS);

    localparam logic [MAG_BITS-1:0]  NEG_LIMIT = MAG_BITS'(1 << (ELEV_BITS - 1));
    localparam logic [MAG_BITS-1:0]  POS_LIMIT = MAG_BITS'((1 << (ELEV_BITS - 1)) - 1);
    localparam logic [ELEV_BITS-1:0] ELEV_MIN  = ELEV_BITS'(1 << (ELEV_BITS - 1));
    localparam logic [ELEV_BITS-1:0] ELEV_MAX  = ELEV_BITS'((1 << (ELEV_BITS - 1)) - 1);

    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic       vld;
        logic       query;
        logic       first;
        logic       last;
        logic       used;
        logic [1:0] k;
    } t_tag;

endpackage

`default_nettype wire

// File: hw/rtl/heightmap_bilinear_sampler.sv
// Heightmap bilinear sampler: height grid memory, corner sequencer and weighting pipeline.
//
// Channel   Dir  Handshake             Payload
// s         in   i_s_tvalid/o_s_tready tdata: index, sample, x, y; tuser: mode
// m         out  o_m_tvalid/i_m_tready tdata: elevation; tuser: in_range
// apb       in   psel/penable/pready   grid_width at 0x0, grid_height at 0x4
//
// A query inside the grid reads its four corners in turn from the single-port grid memory,
// one corner per cycle unless the pipeline stalls; loads and queries outside the grid
// read none. The last corner read or the accepted beat passes through the r_a, r_b,
// r_c and output registers. Reset is synchronous; the grid memory is not cleared.
// The pipeline stalls only when a finished beat cannot move into the full output register.
`default_nettype none

module heightmap_bilinear_sampler
    import hbs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [63:0] i_s_tdata,   // load_index, sample_height, x_coord, y_coord
    input  wire  [0:0]  i_s_tuser,   // mode
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [23:0] o_m_tdata,   // elevation
    output logic [0:0]  o_m_tuser,   // in_range
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_C1   = 2'd1;
    localparam logic [1:0] ST_C2   = 2'd2;
    localparam logic [1:0] ST_C3   = 2'd3;

    logic [HEIGHT_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];

    logic [DIM_BITS-1:0]    r_gw, r_gh;
    logic [1:0]             r_state, n_state;
    logic [FRAC_BITS-1:0]   r_fx, r_fy;
    logic [ADDR_BITS-1:0]   r_v;
    logic                   r_right, r_down;
    logic [1:0]             r_k;
    logic [HEIGHT_BITS-1:0] r_rdata;
    t_tag                   r_a, r_b, r_c;
    logic [WT_BITS-1:0]     r_a_w;
    logic signed [PROD_BITS-1:0] r_b_prod, r_acc;
    logic                   r_out_vld;
    logic [ELEV_BITS-1:0]   r_out_elev;
    logic                   r_out_inr;

    logic                   w_mode;
    logic [CELL_BITS-1:0]   w_c, w_r;
    logic [FRAC_BITS-1:0]   w_fx_in, w_fy_in, w_fx, w_fy;
    logic                   w_inr, w_right_in, w_down_in, w_right, w_down;
    logic [1:0]             w_k_in, w_k;
    logic [ADDR_BITS-1:0]   w_v_in, w_raddr, w_addr;
    logic                   w_en, w_acc_in, w_go, w_busy;
    logic                   w_mem_en, w_mem_we;
    logic [1:0]             w_corner;
    logic [FRAC_BITS:0]     w_wa, w_wb;
    logic [WT_BITS-1:0]     w_w;
    logic                   w_used;
    logic [PROD_BITS-1:0]   w_mag;
    logic [SH_BITS-1:0]     w_shifted;
    logic [MAG_BITS-1:0]    w_q;
    logic [ELEV_BITS-1:0]   w_elev;
    logic                   w_cfg_we;
    logic [DIM_BITS-1:0]    w_cfg_val;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready;
    assign w_cfg_val = (pwdata[DIM_BITS-1:0] > MAX_DIM) ? MAX_DIM : pwdata[DIM_BITS-1:0];
    assign prdata   = (paddr[2] == REG_GRID_HEIGHT) ? {{(32-DIM_BITS){1'b0}}, r_gh}
                                                    : {{(32-DIM_BITS){1'b0}}, r_gw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= MAX_DIM;
            r_gh <= MAX_DIM;
        end else if (w_cfg_we) begin
            if (paddr[2] == REG_GRID_HEIGHT) begin
                r_gh <= w_cfg_val;
            end else begin
                r_gw <= w_cfg_val;
            end
        end
    end

    assign w_mode  = i_s_tuser[0];
    assign w_c     = i_s_tdata[32+FRAC_BITS +: CELL_BITS];
    assign w_r     = i_s_tdata[48+FRAC_BITS +: CELL_BITS];
    assign w_fx_in = i_s_tdata[32 +: FRAC_BITS];
    assign w_fy_in = i_s_tdata[48 +: FRAC_BITS];

    assign w_inr      = ({1'b0, w_c} < r_gw) && ({1'b0, w_r} < r_gh);
    assign w_right_in = (({1'b0, w_c} + DIM_BITS'(1)) < r_gw);
    assign w_down_in  = (({1'b0, w_r} + DIM_BITS'(1)) < r_gh);
    assign w_k_in     = (w_right_in && w_down_in) ? 2'd0
                      : ((w_right_in || w_down_in) ? 2'd1 : 2'd2);
    assign w_v_in     = ADDR_BITS'(w_r) * ADDR_BITS'(r_gw) + ADDR_BITS'(w_c);

    assign w_en     = !(r_c.vld && r_out_vld && !i_m_tready);
    assign w_busy   = (r_state != ST_IDLE);
    assign o_s_tready = !w_busy && w_en;
    assign w_acc_in = i_s_tvalid && o_s_tready;
    assign w_go     = w_acc_in && (w_mode == MODE_QUERY) && w_inr;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = w_go ? ST_C1 : ST_IDLE;
            ST_C1:   n_state = ST_C2;
            ST_C2:   n_state = ST_C3;
            ST_C3:   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_C1:   w_raddr = r_v + ADDR_BITS'(1);
            ST_C2:   w_raddr = r_v + ADDR_BITS'(r_gw);
            ST_C3:   w_raddr = r_v + ADDR_BITS'(r_gw) + ADDR_BITS'(1);
            default: w_raddr = w_v_in;
        endcase
    end

    assign w_mem_we = w_acc_in && (w_mode == MODE_LOAD);
    assign w_mem_en = w_mem_we || w_go || (w_busy && w_en);
    assign w_addr   = w_mem_we ? i_s_tdata[0 +: ADDR_BITS] : w_raddr;

    always_ff @(posedge i_clk) begin
        if (w_mem_en) begin
            if (w_mem_we) begin
                mem[w_addr] <= i_s_tdata[16 +: HEIGHT_BITS];
            end else begin
                r_rdata <= mem[w_addr];
            end
        end
    end

    assign w_corner = r_state;
    assign w_fx     = w_busy ? r_fx : w_fx_in;
    assign w_fy     = w_busy ? r_fy : w_fy_in;
    assign w_right  = w_busy ? r_right : w_right_in;
    assign w_down   = w_busy ? r_down : w_down_in;
    assign w_k      = w_busy ? r_k : w_k_in;
    assign w_wa     = w_corner[0] ? {1'b0, w_fx} : (FRAC_ONE - {1'b0, w_fx});
    assign w_wb     = w_corner[1] ? {1'b0, w_fy} : (FRAC_ONE - {1'b0, w_fy});
    assign w_w      = WT_BITS'(w_wa) * WT_BITS'(w_wb);

    always_comb begin
        case (w_corner)
            2'd1:    w_used = w_right;
            2'd2:    w_used = w_down;
            2'd3:    w_used = w_right && w_down;
            default: w_used = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
        end else if (w_en) begin
            r_state   <= n_state;
            r_a.vld   <= w_acc_in || w_busy;
            r_a.query <= w_busy || w_go;
            r_a.first <= !w_busy;
            r_a.last  <= w_busy ? (r_state == ST_C3) : !w_go;
            r_a.used  <= (w_busy || w_go) && w_used;
            r_a.k     <= w_k;
            r_b       <= r_a;
            r_c.vld   <= r_b.vld && r_b.last;
            r_c.query <= r_b.query;
            r_c.first <= r_b.first;
            r_c.last  <= r_b.last;
            r_c.used  <= r_b.used;
            r_c.k     <= r_b.k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_go) begin
                r_fx    <= w_fx_in;
                r_fy    <= w_fy_in;
                r_v     <= w_v_in;
                r_right <= w_right_in;
                r_down  <= w_down_in;
                r_k     <= w_k_in;
            end
            r_a_w <= w_w;
            if (r_a.used) begin
                r_b_prod <= PROD_BITS'($signed(r_rdata))
                          * PROD_BITS'($signed({1'b0, r_a_w}));
            end else begin
                r_b_prod <= '0;
            end
            if (r_b.vld) begin
                r_acc <= r_b.first ? r_b_prod : (r_acc + r_b_prod);
            end
        end
    end

    assign w_mag     = r_acc[PROD_BITS-1] ? PROD_BITS'(-r_acc) : PROD_BITS'(r_acc);
    assign w_shifted = {2'b00, w_mag} << r_c.k;
    assign w_q       = MAG_BITS'(w_shifted >> (2 * FRAC_BITS));

    always_comb begin
        if (!r_c.query) begin
            w_elev = '0;
        end else if (r_acc[PROD_BITS-1]) begin
            w_elev = (w_q > NEG_LIMIT) ? ELEV_MIN : ELEV_BITS'(-w_q);
        end else begin
            w_elev = (w_q > POS_LIMIT) ? ELEV_MAX : w_q[ELEV_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_c.vld && w_en) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c.vld && w_en) begin
            r_out_elev <= w_elev;
            r_out_inr  <= r_c.query;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(24-ELEV_BITS){1'b0}}, r_out_elev};
    assign o_m_tuser  = r_out_inr;

endmodule

`default_nettype wire

// File: tb/sv/heightmap_bilinear_sampler_tb.sv
// Self-checking testbench for the heightmap bilinear sampler with its own elevation predictor.
`timescale 1ns / 100ps

module heightmap_bilinear_sampler_tb;
    import hbs_pkg::*;

    localparam int STORE_DEPTH   = 1 << ADDR_BITS;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 40;
    localparam int N_PHASES      = 9;

    typedef struct packed {
        logic                   mode;
        logic [15:0]            index;
        logic [15:0]            sample;
        logic [15:0]            x;
        logic [15:0]            y;
        logic                   typed;
        logic [ELEV_BITS-1:0]   elev;
        logic                   inr;
    } t_beat;

    typedef struct packed {
        logic [ELEV_BITS-1:0]   elev;
        logic                   inr;
    } t_result;

    localparam t_beat DIR_ROWS [17] = '{
        '{MODE_LOAD,  16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1, 19'd0,     1'b0},
        '{MODE_LOAD,  16'h0001, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b1, 19'd0,     1'b0},
        '{MODE_LOAD,  16'h0002, 16'h0100, 16'h0000, 16'h0000, 1'b1, 19'd0,     1'b0},
        '{MODE_LOAD,  16'h0003, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 19'd0,     1'b0},
        '{MODE_LOAD,  16'hFFFF, 16'h5A5A, 16'h0000, 16'h0000, 1'b1, 19'd0,     1'b0},
        '{MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, 19'd32767, 1'b1},
        '{MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'h0080, 16'h0000, 1'b0, 19'd0,     1'b0},
        '{MODE_QUERY, 16'h0000, 16'h0000, 16'h01FF, 16'h01FF, 1'b0, 19'd0,     1'b0},
        '{MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'h0180, 16'h0000, 1'b0, 19'd0,     1'b0},
        '{MODE_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h0180, 1'b0, 19'd0,     1'b0},
        '{MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'h00FF, 1'b0, 19'd0,     1'b0},
        '{MODE_QUERY, 16'h0000, 16'h0000, 16'h0200, 16'h0000, 1'b1, 19'd0,     1'b0},
        '{MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0200, 1'b1, 19'd0,     1'b0},
        '{MODE_QUERY, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 19'd0,     1'b0},
        '{MODE_QUERY, 16'hFFFF, 16'hFFFF, 16'h0100, 16'h0100, 1'b0, 19'd0,     1'b0},
        '{MODE_LOAD,  16'h0002, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1, 19'd0,     1'b0},
        '{MODE_QUERY, 16'h0000, 16'h0000, 16'h0000, 16'h01FF, 1'b0, 19'd0,     1'b0}
    };

    localparam int PH_W [N_PHASES] = '{511, 1, 256, 1, 0, 9, 16, 3, 200};
    localparam int PH_H [N_PHASES] = '{256, 1, 1, 256, 7, 0, 12, 200, 3};
    localparam int PH_N [N_PHASES] = '{225, 150, 200, 200, 80, 80, 300, 300, 300};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [23:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic [31:0] prdata;
    logic        pready;

    logic signed [HEIGHT_BITS-1:0] height_mem [0:STORE_DEPTH-1];
    bit          written [0:STORE_DEPTH-1];
    int          dim_w = 256;
    int          dim_h = 256;

    t_result     elev_due_q [$];
    int          mismatch_cnt = 0;
    int          src_idle_pct = 0;
    int          snk_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    heightmap_bilinear_sampler dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_result interp_elevation(logic [15:0] x, logic [15:0] y);
        int      c, r, fx, fy, v, k, one;
        bit      right, down;
        longint  acc, mag, q, e, lim;
        t_result res;
        res = '0;
        one = 1 << FRAC_BITS;
        c = int'(x) >> FRAC_BITS;
        r = int'(y) >> FRAC_BITS;
        fx = int'(x) & (one - 1);
        fy = int'(y) & (one - 1);
        if (c >= dim_w || r >= dim_h) begin
            return res;
        end
        v = r * dim_w + c;
        right = (c + 1 < dim_w);
        down = (r + 1 < dim_h);
        acc = longint'(height_mem[v]) * longint'((one - fx) * (one - fy));
        if (right) begin
            acc += longint'(height_mem[v + 1]) * longint'(fx * (one - fy));
        end
        if (down) begin
            acc += longint'(height_mem[v + dim_w]) * longint'((one - fx) * fy);
        end
        if (right && down) begin
            acc += longint'(height_mem[v + dim_w + 1]) * longint'(fx * fy);
        end
        k = (right && down) ? 0 : ((right || down) ? 1 : 2);
        mag = (acc < 0) ? -acc : acc;
        q = mag >> (2 * FRAC_BITS - k);
        lim = longint'(1) << (ELEV_BITS - 1);
        if (acc < 0) begin
            e = (q > lim) ? -lim : -q;
        end else begin
            e = (q > lim - 1) ? lim - 1 : q;
        end
        res.elev = e[ELEV_BITS-1:0];
        res.inr = 1'b1;
        return res;
    endfunction

    function automatic t_result settle_beat(t_beat b);
        t_result res;
        res = '0;
        if (b.mode == MODE_LOAD) begin
            height_mem[b.index] = b.sample;
            written[b.index] = 1'b1;
        end else begin
            res = interp_elevation(b.x, b.y);
        end
        return b.typed ? t_result'({b.elev, b.inr}) : res;
    endfunction

    function automatic t_beat random_beat(logic mode);
        t_beat b;
        b.mode = mode;
        b.index = 16'($urandom);
        b.sample = 16'($urandom);
        b.x = 16'($urandom);
        b.y = 16'($urandom);
        b.typed = 1'b0;
        b.elev = '0;
        b.inr = 1'b0;
        return b;
    endfunction

    task automatic offer_beat(input t_beat b);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {b.y, b.x, b.sample, b.index};
        s_tuser <= b.mode;
        do @(posedge i_clk); while (!o_s_tready);
        elev_due_q.push_back(settle_beat(b));
    endtask

    task automatic write_reg(input logic reg_idx, input int value);
        int dim;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        dim = value & 'h1FF;
        if (dim > int'(MAX_DIM)) begin
            dim = int'(MAX_DIM);
        end
        if (reg_idx == REG_GRID_WIDTH) begin
            dim_w = dim;
        end else begin
            dim_h = dim;
        end
    endtask

    // Loads any corner of the cell that the query would read and that holds no sample yet.
    task automatic prime_corners(input logic [15:0] x, input logic [15:0] y,
                                 output int n_loads);
        int    c, r, v;
        int    corner_q [$];
        t_beat b;
        n_loads = 0;
        c = int'(x) >> FRAC_BITS;
        r = int'(y) >> FRAC_BITS;
        if (c < dim_w && r < dim_h) begin
            v = r * dim_w + c;
            corner_q.push_back(v);
            if (c + 1 < dim_w) begin
                corner_q.push_back(v + 1);
            end
            if (r + 1 < dim_h) begin
                corner_q.push_back(v + dim_w);
            end
            if (c + 1 < dim_w && r + 1 < dim_h) begin
                corner_q.push_back(v + dim_w + 1);
            end
            foreach (corner_q[i]) begin
                if (!written[corner_q[i]]) begin
                    b = random_beat(MODE_LOAD);
                    b.index = 16'(corner_q[i]);
                    offer_beat(b);
                    n_loads++;
                end
            end
        end
    endtask

    task automatic run_phase(input int n_items);
        int    pick, cells, sent, n_primed;
        t_beat b;
        cells = dim_w * dim_h;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                b = random_beat(MODE_LOAD);
                if (cells > 0 && $urandom_range(9) < 7) begin
                    b.index = 16'($urandom_range(cells - 1));
                end
            end else begin
                b = random_beat(MODE_QUERY);
                if (pick < 90 && cells > 0) begin
                    b.x[15:FRAC_BITS] = CELL_BITS'($urandom_range(dim_w - 1));
                    b.y[15:FRAC_BITS] = CELL_BITS'($urandom_range(dim_h - 1));
                end
                prime_corners(b.x, b.y, n_primed);
                sent += n_primed;
            end
            offer_beat(b);
            sent++;
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic settle_idle();
        while (elev_due_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result due;
        if (i_rst_n && o_m_tvalid && m_tready) begin
            if (elev_due_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_REPORTS) begin
                    $display("%0t: unexpected result beat, elevation %0d in_range %0b",
                             $time, $signed(o_m_tdata[ELEV_BITS-1:0]), o_m_tuser[0]);
                end
            end else begin
                due = elev_due_q.pop_front();
                if (o_m_tdata[ELEV_BITS-1:0] !== due.elev || o_m_tuser[0] !== due.inr) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("%0t: expected elevation %0d in_range %0b, got %0d %0b",
                                 $time, $signed(due.elev), due.inr,
                                 $signed(o_m_tdata[ELEV_BITS-1:0]), o_m_tuser[0]);
                    end
                end
            end
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(REG_GRID_WIDTH, 2);
        write_reg(REG_GRID_HEIGHT, 2);
        foreach (DIR_ROWS[i]) begin
            offer_beat(DIR_ROWS[i]);
        end
        s_tvalid <= 1'b0;
        settle_idle();
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(REG_GRID_WIDTH, PH_W[p]);
            write_reg(REG_GRID_HEIGHT, PH_H[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
                default: begin src_idle_pct = 19; snk_stall_pct = 19; end
            endcase
            if (p == 0) begin
                hold_req <= 1'b1;
            end
            run_phase(PH_N[p]);
            settle_idle();
        end
        if (mismatch_cnt == 0) begin
            $display("[heightmap_bilinear_sampler] OK");
        end else begin
            $display("[heightmap_bilinear_sampler] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[heightmap_bilinear_sampler] ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/hbs_pkg.sv
hw/rtl/heightmap_bilinear_sampler.sv
tb/sv/heightmap_bilinear_sampler_tb.sv
